### rtl/lprd_pkg.sv
// Shared types and constants for the length-prefixed request deframer.
`default_nettype none

package lprd_pkg;

  // Number of bytes in a little-endian count or length prefix
  localparam int unsigned PREFIX_BYTES = 4;
  localparam logic [1:0]  PREFIX_LAST  = 2'(PREFIX_BYTES - 1);

  // Reset value of the argument limit register
  localparam logic [15:0] MAX_ARGS_RESET = 16'd1024;

  // Register index of the argument limit
  localparam logic REG_MAX_ARGS = 1'b0;

  // Parser phase
  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_TAIL  = 2'd3
  } phase_t;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_HDR = 3'd1,
    ST_TOO_MANY  = 3'd2,
    ST_SHORT_STR = 3'd3,
    ST_TRAILING  = 3'd4
  } status_t;

  // One result transaction
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  payload_byte;
    logic [15:0] arg_index;
    logic        arg_end;
    logic        frame_done;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

### rtl/lprd_parser.sv
// Frame parser: prefix decoding, payload counting and status for each accepted byte.
`default_nettype none

module lprd_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            frame_last,
  input  wire logic [15:0]     max_args,
  output logic                 emit,
  output lprd_pkg::result_t    result
);
  import lprd_pkg::*;

  phase_t      phase, phase_step, phase_next;
  status_t     error_code, error_step, error_code_next;
  logic [1:0]  prefix_byte_pos, prefix_byte_pos_next;
  logic [23:0] prefix_shift, prefix_shift_next;
  logic [15:0] args_left, args_left_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [15:0] current_arg, current_arg_next;

  logic        act, in_prefix, prefix_end, count_end, too_many;
  logic        len_zero, len_set, data_step, data_end, close_arg, trailing;
  logic [31:0] word, bytes_dec;
  logic [15:0] args_dec;
  status_t     final_status;

  // Decode of the current byte against the frame state
  always_comb begin
    act        = accept && (error_code == ST_OK);
    in_prefix  = (phase == PH_COUNT) || (phase == PH_LEN);
    word       = {data_byte, prefix_shift};
    prefix_end = act && in_prefix && (prefix_byte_pos == PREFIX_LAST);
    count_end  = prefix_end && (phase == PH_COUNT);
    too_many   = count_end && (word > {16'd0, max_args});
    len_zero   = prefix_end && (phase == PH_LEN) && (word == 32'd0);
    len_set    = prefix_end && (phase == PH_LEN) && (word != 32'd0);
    data_step  = act && (phase == PH_DATA);
    bytes_dec  = bytes_left - 32'd1;
    data_end   = data_step && (bytes_dec == 32'd0);
    close_arg  = len_zero || data_end;
    args_dec   = args_left - 16'd1;
    trailing   = act && (phase == PH_TAIL);
  end

  // Next phase
  always_comb begin
    priority if (count_end && !too_many) begin
      phase_step = (word != 32'd0) ? PH_LEN : PH_TAIL;
    end else if (len_set) begin
      phase_step = PH_DATA;
    end else if (close_arg) begin
      phase_step = (args_dec != 16'd0) ? PH_LEN : PH_TAIL;
    end else begin
      phase_step = phase;
    end
    phase_next = (accept && frame_last) ? PH_COUNT : phase_step;
  end

  // Error latch and end-of-frame status
  always_comb begin
    priority if (too_many) begin
      error_step = ST_TOO_MANY;
    end else if (trailing) begin
      error_step = ST_TRAILING;
    end else begin
      error_step = error_code;
    end

    priority if (error_step != ST_OK) begin
      final_status = error_step;
    end else if (phase_step == PH_TAIL) begin
      final_status = ST_OK;
    end else if (phase_step == PH_DATA) begin
      final_status = ST_SHORT_STR;
    end else begin
      final_status = ST_SHORT_HDR;
    end

    error_code_next = (accept && frame_last) ? ST_OK : error_step;
  end

  // Counters and prefix accumulator
  always_comb begin
    prefix_byte_pos_next = prefix_byte_pos;
    prefix_shift_next    = prefix_shift;
    args_left_next       = args_left;
    bytes_left_next      = bytes_left;
    current_arg_next     = current_arg;

    if (act && in_prefix) begin
      if (prefix_byte_pos == PREFIX_LAST) begin
        prefix_byte_pos_next = 2'd0;
        prefix_shift_next    = 24'd0;
      end else begin
        prefix_byte_pos_next = prefix_byte_pos + 2'd1;
        prefix_shift_next    = prefix_shift | ({16'd0, data_byte} << {prefix_byte_pos, 3'b000});
      end
    end
    if (count_end && !too_many) begin
      args_left_next   = word[15:0];
      current_arg_next = 16'd0;
    end
    if (len_set) begin
      bytes_left_next = word;
    end
    if (data_step) begin
      bytes_left_next = bytes_dec;
    end
    if (close_arg) begin
      args_left_next   = args_dec;
      current_arg_next = current_arg + 16'd1;
    end
    // End of frame returns everything to its reset state
    if (accept && frame_last) begin
      prefix_byte_pos_next = 2'd0;
      prefix_shift_next    = 24'd0;
      args_left_next       = 16'd0;
      bytes_left_next      = 32'd0;
      current_arg_next     = 16'd0;
    end
  end

  // Result transaction for this byte
  always_comb begin
    emit                = accept && (close_arg || data_step || frame_last);
    result.has_byte     = data_step;
    result.payload_byte = data_step ? data_byte : 8'd0;
    result.arg_index    = (close_arg || data_step) ? current_arg : 16'd0;
    result.arg_end      = close_arg;
    result.frame_done   = frame_last;
    result.status       = frame_last ? final_status : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COUNT;
      error_code      <= ST_OK;
      prefix_byte_pos <= 2'd0;
      prefix_shift    <= 24'd0;
      args_left       <= 16'd0;
      bytes_left      <= 32'd0;
      current_arg     <= 16'd0;
    end else begin
      phase           <= phase_next;
      error_code      <= error_code_next;
      prefix_byte_pos <= prefix_byte_pos_next;
      prefix_shift    <= prefix_shift_next;
      args_left       <= args_left_next;
      bytes_left      <= bytes_left_next;
      current_arg     <= current_arg_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lprd_out_buf.sv
// Two-entry result buffer between the parser and the output stream.
`default_nettype none

module lprd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lprd_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lprd_pkg::result_t      out_data
);
  import lprd_pkg::*;

  result_t    slot [2];
  logic [1:0] count, count_next;
  logic       wr_ptr, rd_ptr;
  logic       pop;

  // Occupancy and head entry
  always_comb begin
    full      = (count == 2'd2);
    out_valid = (count != 2'd0);
    out_data  = slot[rd_ptr];
    pop       = out_valid && out_ready;
    unique case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/length_prefixed_request_deframer.sv
// Top level of the length-prefixed request deframer.
//
// Input stream: one request body byte per transaction on s_tdata, s_tlast on
// the final byte. Output stream: at most one result per input byte, carrying
// a payload byte (m_tuser high), an end-of-argument mark, or on the final
// byte the frame status with m_tlast high. Zero-length arguments give an end
// mark with no byte. Payload already delivered must be dropped by the user
// when the frame status is not ok.
// Throughput: one byte per cycle while the buffer has room. Each byte is
// parsed in one pass of combinational logic straight into a two-entry result
// buffer and is delivered from there once earlier results have been taken.
// Stall: while the receiver holds m_tready low the buffer fills; s_tready
// drops only when both entries are occupied, and parsing resumes as soon as
// one is taken.
// Reset: frame state returns to waiting for an argument count and max_args
// returns to 1024. max_args is written through the APB port at address 0 and
// must only change between frames.
`default_nettype none

module length_prefixed_request_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
  input  wire logic        s_tlast,
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,    // [7:0] payload_byte, [23:8] arg_index,
                                       // [24] arg_end, [27:25] status, [31:28] zero
  output logic             m_tuser,    // [0] has_byte
  output logic             m_tlast,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lprd_pkg::*;

  logic [15:0] max_args;
  logic        accept, emit, buf_full;
  result_t     result, head;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_args <= MAX_ARGS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_ARGS)) begin
      max_args <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = (paddr[2] == REG_MAX_ARGS) ? {16'd0, max_args} : 32'd0;
  end

  // Byte parser
  assign s_tready = !buf_full;
  assign accept   = s_tvalid && s_tready;

  lprd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .frame_last (s_tlast),
    .max_args   (max_args),
    .emit       (emit),
    .result     (result)
  );

  // Result buffer
  lprd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (result),
    .full      (buf_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head)
  );

  // Output packing
  always_comb begin
    m_tdata = {4'd0, head.status, head.arg_end, head.arg_index, head.payload_byte};
    m_tuser = head.has_byte;
    m_tlast = head.frame_done;
  end

  // Only a frame end carries a status
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[27:25] == ST_OK)
    else $error("status set on a result without frame end");

  // A result without a byte carries a zero payload
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("payload byte set without has_byte");

  // Every result has a reason: a byte, an end mark or a frame end
  a_result_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser || m_tdata[24] || m_tlast)
    else $error("empty result delivered");

  // After any pushed result, m_tvalid is high the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid)
    else $error("pushed result not visible");

endmodule

`default_nettype wire
